// ===== hdl/iprc_pkg.sv =====
// Package for the ICMP probe reply classifier.
// Holds the header lengths, protocol codes, verdict codes and register indexes.
// No dependencies; every file of the block imports it.
`default_nettype none

package iprc_pkg;

    localparam int unsigned ByteW      = 8;
    localparam int unsigned SeqW       = 16;
    localparam int unsigned AddrW      = 32;
    localparam int unsigned PortW      = 16;
    localparam int unsigned CountW     = 16;
    localparam int unsigned HdrLenW    = 6;
    localparam int unsigned CfgDataW   = 32;
    localparam int unsigned CfgIndexW  = 1;
    localparam int unsigned STdataW    = 24;
    localparam int unsigned MTdataW    = 40;

    localparam logic [CountW-1:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [CountW-1:0] MIN_IP_HEADER  = 16'd20;
    localparam logic [CountW-1:0] ICMP_HDR_BYTES = 16'd8;
    localparam logic [CountW-1:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [3:0]        IP_VERSION_4   = 4'd4;
    localparam logic [7:0]        PROTO_UDP      = 8'd17;
    localparam logic [7:0]        TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0]        TYPE_UNREACHABLE   = 8'd3;
    localparam logic [PortW-1:0]  BASE_PORT_RESET    = 16'd33434;

    typedef enum logic [1:0] {
        VERDICT_IGNORED       = 2'd0,
        VERDICT_TIME_EXCEEDED = 2'd1,
        VERDICT_UNREACHABLE   = 2'd2
    } verdict_t;

    typedef enum logic [CfgIndexW-1:0] {
        REG_TARGET_ADDRESS = 1'd0,
        REG_BASE_PORT      = 1'd1
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hdl/icmp_probe_reply_classifier_unit.sv =====
// Top level of the ICMP probe reply classifier: byte-wise packet parser and verdict.
// Depends on iprc_pkg; the checker in iprc_checker.sv binds to this module.
//
// Channel   Dir  Handshake          Payload
// s_        in   tvalid/tready      tdata {probe_seq[23:8], packet_byte[7:0]}, tlast
// m_        out  tvalid/tready      tdata {zero[39:34], router_address[33:2], verdict[1:0]}
// cfg_      in   we, no wait        index, wdata
//
// One byte is taken per cycle unless the input stalls. A byte goes into the input register
// and updates the field captures when it advances; for the final byte that same edge loads
// the verdict into the result register. Only a pending verdict that the sink does not take
// stalls the input, and only once the next final byte waits in the input register.
// Reset is synchronous; it clears per-packet state, valid flags and the target register.
`default_nettype none

module icmp_probe_reply_classifier_unit #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [iprc_pkg::STdataW-1:0]      s_tdata,   // packet_byte[7:0], probe_seq[23:8]
    input  wire                               s_tlast,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [iprc_pkg::MTdataW-1:0]      m_tdata,   // verdict[1:0], router_address[33:2]
    input  wire                               cfg_we,
    input  wire  [iprc_pkg::CfgIndexW-1:0]    cfg_index,
    input  wire  [iprc_pkg::CfgDataW-1:0]     cfg_wdata
);
    import iprc_pkg::*;

    localparam logic [CountW-1:0] MaxLen = CountW'(MAX_PACKET_BYTES);

    // Configuration registers.
    logic [AddrW-1:0] target_reg;
    logic [PortW-1:0] base_port_reg;

    // Input stage.
    logic              in_valid_reg;
    logic [ByteW-1:0]  in_byte_reg;
    logic [SeqW-1:0]   in_seq_reg;
    logic              in_last_reg;

    // Per-packet state.
    logic [CountW-1:0]  count_reg,      count_next;
    logic [HdrLenW-1:0] outer_len_reg,  outer_len_next;
    logic               version_ok_reg, version_ok_next;
    logic [7:0]         kind_reg,       kind_next;
    logic [HdrLenW-1:0] inner_len_reg,  inner_len_next;
    logic [7:0]         proto_reg,      proto_next;
    logic [AddrW-1:0]   inner_dst_reg,  inner_dst_next;
    logic [PortW-1:0]   udp_port_reg,   udp_port_next;
    logic [AddrW-1:0]   src_reg,        src_next;

    // Result stage.
    logic              out_valid_reg;
    verdict_t          out_verdict_reg, verdict_next;
    logic [AddrW-1:0]  out_router_reg;

    logic              advance;
    logic              load_out;
    logic [CountW-1:0] pos;
    logic [CountW-1:0] inner_off;
    logic [CountW-1:0] udp_off;
    logic [CountW-1:0] len;
    logic [CountW-1:0] icmp_end;
    logic [PortW-1:0]  want_port;
    logic              probe_ok;

    // A non-final byte never waits; a final byte waits for room in the result register.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign load_out = advance && in_last_reg;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(MTdataW - AddrW - 2)'(0), out_router_reg, out_verdict_reg};

    // Field captures at fixed offsets relative to the header lengths seen so far.
    always_comb begin
        pos       = count_reg;
        inner_off = CountW'(outer_len_reg) + ICMP_HDR_BYTES;
        udp_off   = inner_off + CountW'(inner_len_reg);

        count_next      = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        outer_len_next  = outer_len_reg;
        version_ok_next = version_ok_reg;
        kind_next       = kind_reg;
        inner_len_next  = inner_len_reg;
        proto_next      = proto_reg;
        inner_dst_next  = inner_dst_reg;
        udp_port_next   = udp_port_reg;
        src_next        = src_reg;

        if (pos < MaxLen) begin
            if (pos == '0) begin
                version_ok_next = (in_byte_reg[7:4] == IP_VERSION_4);
                outer_len_next  = {in_byte_reg[3:0], 2'b00};
            end
            if (pos >= 16'd12 && pos <= 16'd15) begin
                src_next = {src_reg[AddrW-9:0], in_byte_reg};
            end
            // Offset captures start past the fixed header, so a short outer length
            // cannot overwrite the outer source address.
            if (pos >= MIN_IP_HEADER) begin
                if (pos == CountW'(outer_len_reg)) begin
                    kind_next = in_byte_reg;
                end
                if (pos == inner_off) begin
                    inner_len_next = {in_byte_reg[3:0], 2'b00};
                end
                if (pos == inner_off + 16'd9) begin
                    proto_next = in_byte_reg;
                end
                if (pos >= inner_off + 16'd16 && pos <= inner_off + 16'd19) begin
                    inner_dst_next = {inner_dst_reg[AddrW-9:0], in_byte_reg};
                end
                if (pos == udp_off + 16'd2 || pos == udp_off + 16'd3) begin
                    udp_port_next = {udp_port_reg[PortW-9:0], in_byte_reg};
                end
            end
        end
    end

    // Verdict on the state that includes the final byte.
    always_comb begin
        len       = (count_next > MaxLen) ? MaxLen : count_next;
        icmp_end  = CountW'(outer_len_next) + ICMP_HDR_BYTES;
        want_port = base_port_reg + in_seq_reg;
        probe_ok  = (len >= icmp_end + MIN_IP_HEADER + UDP_HDR_BYTES)
                 && (CountW'(inner_len_next) >= MIN_IP_HEADER)
                 && (proto_next == PROTO_UDP)
                 && (inner_dst_next == target_reg)
                 && (len >= icmp_end + CountW'(inner_len_next) + UDP_HDR_BYTES)
                 && (udp_port_next == want_port);

        verdict_next = VERDICT_IGNORED;
        if (len >= MIN_IP_HEADER && version_ok_next
                && CountW'(outer_len_next) >= MIN_IP_HEADER && len >= icmp_end
                && probe_ok) begin
            if (kind_next == TYPE_TIME_EXCEEDED) begin
                verdict_next = VERDICT_TIME_EXCEEDED;
            end else if (kind_next == TYPE_UNREACHABLE) begin
                verdict_next = VERDICT_UNREACHABLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= '0;
            base_port_reg <= BASE_PORT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TARGET_ADDRESS: target_reg    <= cfg_wdata;
                REG_BASE_PORT:      base_port_reg <= cfg_wdata[PortW-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[ByteW-1:0];
            in_seq_reg  <= s_tdata[ByteW +: SeqW];
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || load_out) begin
            count_reg      <= '0;
            outer_len_reg  <= '0;
            version_ok_reg <= 1'b0;
            kind_reg       <= '0;
            inner_len_reg  <= '0;
            proto_reg      <= '0;
            inner_dst_reg  <= '0;
            udp_port_reg   <= '0;
            src_reg        <= '0;
        end else if (advance) begin
            count_reg      <= count_next;
            outer_len_reg  <= outer_len_next;
            version_ok_reg <= version_ok_next;
            kind_reg       <= kind_next;
            inner_len_reg  <= inner_len_next;
            proto_reg      <= proto_next;
            inner_dst_reg  <= inner_dst_next;
            udp_port_reg   <= udp_port_next;
            src_reg        <= src_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= load_out || (out_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_verdict_reg <= verdict_next;
            out_router_reg  <= (verdict_next == VERDICT_IGNORED) ? '0 : src_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/iprc_checker.sv =====
// Port-level checker for the ICMP probe reply classifier, with its bind statement.
// Depends on iprc_pkg and on the port list of icmp_probe_reply_classifier_unit.
`default_nettype none

module iprc_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [iprc_pkg::MTdataW-1:0]   m_tdata
);
    import iprc_pkg::*;

    // A stalled result request keeps its valid and its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // Ignored packets give no router; no verdict beyond unreachable; zero padding.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == VERDICT_IGNORED |-> m_tdata[33:2] == '0)
        else $error("router address given for an ignored packet");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] <= VERDICT_UNREACHABLE && m_tdata[MTdataW-1:34] == '0)
        else $error("bad verdict code or nonzero padding");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result request pending right after reset");

endmodule

bind icmp_probe_reply_classifier_unit iprc_checker u_iprc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/icmp_probe_reply_classifier_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for icmp_probe_reply_classifier_unit: builds ICMP replies that
// quote UDP probes, predicts each verdict and compares it with the block's output.
// Depends on iprc_pkg and the block's RTL only.

module icmp_probe_reply_classifier_unit_tb;
    import iprc_pkg::*;

    localparam int unsigned PacketLimit     = 65535;
    localparam int unsigned SettleCycles    = 8;
    localparam int unsigned HoldCycles      = 300;
    localparam int unsigned MinHeaderLen    = 20;
    localparam int unsigned IcmpHeaderLen   = 8;
    localparam int unsigned UdpHeaderLen    = 8;
    localparam logic [3:0]  MinIhl          = 4'd5;
    localparam logic [3:0]  MaxIhl          = 4'd15;

    typedef struct packed {
        verdict_t         verdict;
        logic [AddrW-1:0] router;
    } reply_t;

    typedef enum int {
        MUT_VERSION,
        MUT_OUTER_IHL,
        MUT_ICMP_TYPE,
        MUT_INNER_IHL,
        MUT_PROTOCOL,
        MUT_DEST,
        MUT_PORT,
        MUT_TRUNCATE,
        MUT_CORRUPT
    } mutation_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [STdataW-1:0]    s_tdata;   // packet_byte[7:0], probe_seq[23:8]
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [MTdataW-1:0]    m_tdata;   // verdict[1:0], router_address[33:2], zero[39:34]
    logic                  cfg_we;
    logic [CfgIndexW-1:0]  cfg_index;
    logic [CfgDataW-1:0]   cfg_wdata;

    // Stimulus controls shared by the test tasks and the sink.
    logic                  quiet;
    logic                  hold_request;
    logic [7:0]            reply_bytes[$];
    logic [AddrW-1:0]      cur_target;
    logic [PortW-1:0]      cur_base;

    // Predictor state: register copies from the writes seen on the port, and packet fields.
    logic [AddrW-1:0]      cfg_target;
    logic [PortW-1:0]      cfg_base;
    logic [CountW-1:0]     pk_count;
    logic [HdrLenW-1:0]    pk_outer_len;
    logic                  pk_version_ok;
    logic [7:0]            pk_icmp_type;
    logic [HdrLenW-1:0]    pk_inner_len;
    logic [7:0]            pk_inner_proto;
    logic [AddrW-1:0]      pk_inner_dest;
    logic [PortW-1:0]      pk_udp_port;
    logic [AddrW-1:0]      pk_source;
    reply_t                verdict_q[$];

    int unsigned           error_count;
    int unsigned           bytes_in;
    int unsigned           packets_sent;
    int unsigned           verdicts_checked;
    int unsigned           matches_seen;

    icmp_probe_reply_classifier_unit #(
        .MAX_PACKET_BYTES(PacketLimit)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic void clear_packet_state();
        pk_count       = '0;
        pk_outer_len   = '0;
        pk_version_ok  = 1'b0;
        pk_icmp_type   = '0;
        pk_inner_len   = '0;
        pk_inner_proto = '0;
        pk_inner_dest  = '0;
        pk_udp_port    = '0;
        pk_source      = '0;
    endfunction

    function automatic verdict_t judge_packet(input logic [SeqW-1:0] seq);
        int unsigned len;
        int unsigned off;
        verdict_t    kind;
        logic [PortW-1:0] want_port;
        len = pk_count;
        if (len > PacketLimit) len = PacketLimit;
        if (len < MinHeaderLen || !pk_version_ok) return VERDICT_IGNORED;
        if (pk_outer_len < MinHeaderLen) return VERDICT_IGNORED;
        if (len < pk_outer_len + IcmpHeaderLen) return VERDICT_IGNORED;
        if (pk_icmp_type == TYPE_TIME_EXCEEDED) begin
            kind = VERDICT_TIME_EXCEEDED;
        end else if (pk_icmp_type == TYPE_UNREACHABLE) begin
            kind = VERDICT_UNREACHABLE;
        end else begin
            return VERDICT_IGNORED;
        end
        off = pk_outer_len + IcmpHeaderLen;
        if (len < off + MinHeaderLen + UdpHeaderLen) return VERDICT_IGNORED;
        if (pk_inner_len < MinHeaderLen) return VERDICT_IGNORED;
        if (pk_inner_proto != PROTO_UDP) return VERDICT_IGNORED;
        if (pk_inner_dest != cfg_target) return VERDICT_IGNORED;
        off = off + pk_inner_len;
        if (len < off + UdpHeaderLen) return VERDICT_IGNORED;
        want_port = cfg_base + seq;
        if (pk_udp_port != want_port) return VERDICT_IGNORED;
        return kind;
    endfunction

    // Field captures work from the offsets known before this byte arrives.
    task automatic classify_byte(input logic [7:0] b, input logic last,
                                 input logic [SeqW-1:0] seq);
        int unsigned pos;
        int unsigned icmp_at;
        int unsigned inner_at;
        int unsigned udp_at;
        reply_t      r;
        pos      = pk_count;
        icmp_at  = pk_outer_len;
        inner_at = icmp_at + IcmpHeaderLen;
        udp_at   = inner_at + pk_inner_len;
        bytes_in++;
        if (pos < PacketLimit) begin
            if (pos == 0) begin
                pk_version_ok = (b[7:4] == IP_VERSION_4);
                pk_outer_len  = {b[3:0], 2'b00};
            end else begin
                if (pos >= 12 && pos <= 15) pk_source = {pk_source[23:0], b};
                if (pos >= MinHeaderLen) begin
                    if (pos == icmp_at) pk_icmp_type = b;
                    if (pos == inner_at) pk_inner_len = {b[3:0], 2'b00};
                    if (pos == inner_at + 9) pk_inner_proto = b;
                    if (pos >= inner_at + 16 && pos <= inner_at + 19) begin
                        pk_inner_dest = {pk_inner_dest[23:0], b};
                    end
                    if (pos == udp_at + 2 || pos == udp_at + 3) begin
                        pk_udp_port = {pk_udp_port[7:0], b};
                    end
                end
            end
        end
        if (pk_count != COUNT_MAX) pk_count++;
        if (last) begin
            r.verdict = judge_packet(seq);
            r.router  = (r.verdict != VERDICT_IGNORED) ? pk_source : '0;
            verdict_q.push_back(r);
            clear_packet_state();
        end
    endtask

    task automatic check_verdict(input logic [MTdataW-1:0] word);
        reply_t want;
        verdicts_checked++;
        if (verdict_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected verdict, expected none, got verdict %0d router %h",
                     $time, word[1:0], word[33:2]);
            return;
        end
        want = verdict_q.pop_front();
        if (word[1:0] != want.verdict) begin
            error_count++;
            $display("%0t: verdict mismatch, expected %0d, got %0d",
                     $time, want.verdict, word[1:0]);
        end
        if (word[33:2] != want.router) begin
            error_count++;
            $display("%0t: router address mismatch, expected %h, got %h",
                     $time, want.router, word[33:2]);
        end
        if (word[MTdataW-1:34] != '0) begin
            error_count++;
            $display("%0t: padding mismatch, expected 0, got %h", $time, word[MTdataW-1:34]);
        end
        if (want.verdict != VERDICT_IGNORED) matches_seen++;
    endtask

    // All sampling happens at the rising edge, before any driven value changes.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) begin
                if (cfg_index == REG_TARGET_ADDRESS) cfg_target = cfg_wdata;
                else cfg_base = cfg_wdata[PortW-1:0];
            end
            if (s_tvalid && s_tready) classify_byte(s_tdata[7:0], s_tlast, s_tdata[23:8]);
            if (m_tvalid && m_tready) check_verdict(m_tdata);
        end
    end

    // Result sink; a hold request stalls it for a long stretch.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 35);
            end
        end
    end

    task automatic send_packet_byte(input logic [7:0] b, input logic last,
                                    input logic [SeqW-1:0] seq);
        if (!quiet && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {seq, b};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // The sequence only matters on the final byte; other bytes carry noise there.
    task automatic send_packet(input logic [SeqW-1:0] seq);
        int unsigned i;
        int unsigned last_at;
        last_at = reply_bytes.size() - 1;
        for (i = 0; i <= last_at; i++) begin
            send_packet_byte(reply_bytes[i], i == last_at,
                             (i == last_at) ? seq : SeqW'($urandom));
        end
        packets_sent++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_config(input logic [AddrW-1:0] target, input logic [31:0] port_word);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_TARGET_ADDRESS;
        cfg_wdata <= target;
        @(posedge aclk);
        cfg_index <= REG_BASE_PORT;
        cfg_wdata <= port_word;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_target = target;
        cur_base   = port_word[PortW-1:0];
    endtask

    // An IHL below five still gets a 20-byte header so that the rest keeps its shape.
    task automatic build_reply(input logic [7:0] icmp_type, input logic [3:0] outer_ihl,
                               input logic [3:0] inner_ihl, input logic [7:0] proto,
                               input logic [AddrW-1:0] dest, input logic [PortW-1:0] dport,
                               input int unsigned tail_len);
        int unsigned i;
        int unsigned inner_at;
        int unsigned udp_at;
        int unsigned total;
        inner_at = ((outer_ihl < MinIhl) ? MinHeaderLen : outer_ihl * 4) + IcmpHeaderLen;
        udp_at   = inner_at + ((inner_ihl < MinIhl) ? MinHeaderLen : inner_ihl * 4);
        total    = udp_at + UdpHeaderLen + tail_len;
        reply_bytes.delete();
        for (i = 0; i < total; i++) reply_bytes.push_back(8'($urandom));
        reply_bytes[0]            = {IP_VERSION_4, outer_ihl};
        reply_bytes[inner_at - IcmpHeaderLen] = icmp_type;
        reply_bytes[inner_at]     = {IP_VERSION_4, inner_ihl};
        reply_bytes[inner_at + 9] = proto;
        for (i = 0; i < 4; i++) reply_bytes[inner_at + 16 + i] = dest[31 - 8 * i -: 8];
        reply_bytes[udp_at + 2]   = dport[15:8];
        reply_bytes[udp_at + 3]   = dport[7:0];
    endtask

    task automatic trim_packet(input int unsigned len);
        while (reply_bytes.size() > len) void'(reply_bytes.pop_back());
    endtask

    function automatic logic [3:0] pick_ihl();
        return ($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : MinIhl;
    endfunction

    task automatic test_default_registers();
        build_reply(TYPE_TIME_EXCEEDED, MinIhl, MinIhl, PROTO_UDP, cur_target,
                    BASE_PORT_RESET, 0);
        send_packet('0);
        // The port sum wraps past 65535 here.
        build_reply(TYPE_UNREACHABLE, MinIhl, MinIhl, PROTO_UDP, cur_target,
                    BASE_PORT_RESET + 16'hFFFF, 4);
        send_packet(16'hFFFF);
    endtask

    task automatic test_short_packets();
        logic [SeqW-1:0]  seq;
        logic [PortW-1:0] port;
        seq  = SeqW'($urandom);
        port = cur_base + seq;
        reply_bytes = {8'hFF};
        send_packet(seq);
        reply_bytes = {8'h00};
        send_packet(seq);
        // Cut a valid reply short of the IP header, the ICMP header and the UDP header.
        build_reply(TYPE_TIME_EXCEEDED, MinIhl, MinIhl, PROTO_UDP, cur_target, port, 0);
        trim_packet(19);
        send_packet(seq);
        build_reply(TYPE_TIME_EXCEEDED, MinIhl, MinIhl, PROTO_UDP, cur_target, port, 0);
        trim_packet(27);
        send_packet(seq);
        build_reply(TYPE_UNREACHABLE, MinIhl, MinIhl, PROTO_UDP, cur_target, port, 0);
        trim_packet(55);
        send_packet(seq);
        build_reply(TYPE_UNREACHABLE, MinIhl, MinIhl, PROTO_UDP, cur_target, port, 0);
        send_packet(seq);
    endtask

    task automatic test_header_checks();
        logic [SeqW-1:0]  seq;
        logic [PortW-1:0] port;
        seq  = SeqW'($urandom);
        port = cur_base + seq;
        build_reply(TYPE_TIME_EXCEEDED, MinIhl, MinIhl, PROTO_UDP, cur_target, port, 2);
        reply_bytes[0][7:4] = 4'd6;
        send_packet(seq);
        build_reply(TYPE_UNREACHABLE, 4'd4, MinIhl, PROTO_UDP, cur_target, port, 2);
        send_packet(seq);
        build_reply(TYPE_UNREACHABLE, MinIhl, 4'd4, PROTO_UDP, cur_target, port, 2);
        send_packet(seq);
        build_reply(8'd0, MinIhl, MinIhl, PROTO_UDP, cur_target, port, 2);
        send_packet(seq);
        build_reply(TYPE_TIME_EXCEEDED, MinIhl, MinIhl, 8'd6, cur_target, port, 2);
        send_packet(seq);
        build_reply(TYPE_TIME_EXCEEDED, MinIhl, MinIhl, PROTO_UDP, cur_target ^ 32'h1, port, 2);
        send_packet(seq);
        build_reply(TYPE_UNREACHABLE, MinIhl, MinIhl, PROTO_UDP, cur_target, port + 16'd1, 2);
        send_packet(seq);
    endtask

    task automatic test_register_extremes();
        write_config(32'hFFFF_FFFF, 32'h0000_FFFF);
        build_reply(TYPE_TIME_EXCEEDED, MinIhl, MinIhl, PROTO_UDP, cur_target, 16'h0000, 0);
        send_packet(16'h0001);
        build_reply(TYPE_UNREACHABLE, MaxIhl, MinIhl, PROTO_UDP, cur_target, 16'hFFFE, 1);
        send_packet(16'hFFFF);
        write_config(32'h0000_0000, 32'hFFFF_0000);
        build_reply(TYPE_UNREACHABLE, MinIhl, MaxIhl, PROTO_UDP, cur_target, 16'hFFFF, 0);
        send_packet(16'hFFFF);
        build_reply(TYPE_TIME_EXCEEDED, MinIhl, MinIhl, PROTO_UDP, cur_target, 16'h0000, 0);
        send_packet(16'h0000);
    endtask

    task automatic test_backpressure();
        int unsigned     k;
        int unsigned     i;
        logic [SeqW-1:0] seq;
        hold_request = 1'b1;
        for (k = 0; k < 8; k++) begin
            seq = SeqW'($urandom);
            if (k % 5 == 0) begin
                build_reply(TYPE_UNREACHABLE, MinIhl, MinIhl, PROTO_UDP, cur_target,
                            cur_base + seq, 0);
            end else begin
                reply_bytes.delete();
                for (i = 0; i < $urandom_range(3, 1); i++) reply_bytes.push_back(8'($urandom));
            end
            send_packet(seq);
        end
    endtask

    task automatic test_random_traffic();
        int unsigned      n;
        int unsigned      i;
        int unsigned      choice;
        mutation_t        mut;
        logic [SeqW-1:0]  seq;
        logic [7:0]       icmp_type;
        logic [3:0]       outer_ihl;
        logic [3:0]       inner_ihl;
        logic [7:0]       proto;
        logic [AddrW-1:0] dest;
        logic [PortW-1:0] dport;
        n = 0;
        while (n < 3) begin
            if (n % 2 == 0) begin
                choice = $urandom_range(3);
                write_config((choice == 0) ? '0 : (choice == 1) ? '1 : AddrW'($urandom),
                             $urandom);
            end
            quiet = (n < 2);
            seq   = SeqW'($urandom);
            choice = $urandom_range(99);
            if (choice < 10) begin
                reply_bytes.delete();
                for (i = 0; i < $urandom_range(60, 1); i++) reply_bytes.push_back(8'($urandom));
            end else begin
                icmp_type = $urandom_range(1) ? TYPE_TIME_EXCEEDED : TYPE_UNREACHABLE;
                outer_ihl = pick_ihl();
                inner_ihl = pick_ihl();
                proto     = PROTO_UDP;
                dest      = cur_target;
                dport     = cur_base + seq;
                mut       = mutation_t'($urandom_range(MUT_CORRUPT));
                if (choice >= 65) begin
                    case (mut)
                        MUT_OUTER_IHL: outer_ihl = 4'($urandom_range(4));
                        MUT_ICMP_TYPE: icmp_type = 8'($urandom);
                        MUT_INNER_IHL: inner_ihl = 4'($urandom_range(4));
                        MUT_PROTOCOL:  proto = proto ^ 8'($urandom_range(255, 1));
                        MUT_DEST:      dest = dest ^ (32'h1 << $urandom_range(31));
                        MUT_PORT:      dport = dport + 16'($urandom_range(65535, 1));
                        default: ;
                    endcase
                end
                build_reply(icmp_type, outer_ihl, inner_ihl, proto, dest, dport,
                            $urandom_range(1) ? 0 : $urandom_range(24));
                if (choice >= 65) begin
                    case (mut)
                        MUT_VERSION: reply_bytes[0][7:4] = 4'($urandom_range(15, 5));
                        MUT_TRUNCATE: trim_packet($urandom_range(reply_bytes.size() - 1, 1));
                        MUT_CORRUPT: begin
                            i = $urandom_range(reply_bytes.size() - 1);
                            reply_bytes[i] = reply_bytes[i] ^ 8'($urandom_range(255, 1));
                        end
                        default: ;
                    endcase
                end
            end
            send_packet(seq);
            n++;
        end
        quiet = 1'b0;
    endtask

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_TARGET_ADDRESS;
        cfg_wdata    = '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        cur_target   = '0;
        cur_base     = BASE_PORT_RESET;
        cfg_target   = '0;
        cfg_base     = BASE_PORT_RESET;
        error_count      = 0;
        bytes_in         = 0;
        packets_sent     = 0;
        verdicts_checked = 0;
        matches_seen     = 0;
        clear_packet_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_registers();
        write_config($urandom, $urandom);
        test_short_packets();
        test_header_checks();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        wait_for_drain();

        $display("Sent %0d packets (%0d bytes) under several register settings.",
                 packets_sent, bytes_in);
        $display("Checked %0d verdicts, %0d of them probe matches.",
                 verdicts_checked, matches_seen);
        if (error_count == 0) begin
            $display("** icmp_probe_reply_classifier_unit: PASSED **");
        end else begin
            $display("** icmp_probe_reply_classifier_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Timeout with %0d verdicts still outstanding.", verdict_q.size());
        $display("** icmp_probe_reply_classifier_unit: FAILED **");
        $finish;
    end

endmodule
